>>> sv/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg: shared types and constants of the read depth clipper
// Field widths, reset values, the sequencer state type and the control
// word that the sequencer hands to each storage cell.
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int POS_W          = 31;       // width of a start or end coordinate
    localparam int LIM_W          = 16;       // width of the depth limit register
    localparam int OUT_W          = 9;        // width of the reported counts
    localparam int FIFO_DEPTH_DEF = 256;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 16'hFFFF;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Control word of one cell: shift takes the neighbour's entry, load takes
    // the incoming end coordinate.
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

>>> sv/rdc_cell.sv
// ----------------------------------------------------------------------------
// rdc_cell: one entry of the end coordinate queue
// Holds one end coordinate. On a pop it takes its upstream neighbour's entry,
// so the oldest entry always sits in the first cell of the row.
// ----------------------------------------------------------------------------
module rdc_cell
    import rdc_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [POS_W-1:0] i_next,
    input  logic [POS_W-1:0] i_load_val,
    output logic [POS_W-1:0] o_data
);

    logic [POS_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_data <= i_next;
        end else if (i_ctl.load) begin
            r_data <= i_load_val;
        end
    end

    assign o_data = r_data;

endmodule

>>> sv/read_depth_clipper.sv
// ----------------------------------------------------------------------------
// read_depth_clipper: coverage clipping of position-sorted read intervals
// Keeps the end coordinates of open reads in a row of shifting cells, retires
// those that end before the new read starts, stores the new end and decides
// whether the read is kept under the configured depth limit.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+---------------------------
//   input    | in        | i_valid / o_ready       | i_read_start, i_read_end
//   result   | out       | o_valid / i_ready       | o_keep, o_occupancy,
//            |           |                         | o_peak_occupancy, o_overflow
//   config   | in        | i_cfg_valid/o_cfg_ready | i_cfg_data (depth limit)
//
// A read is taken in by the input transfer, then retires the entries that it
// passes (the cell row shifts by one place a cycle), and last stores the end
// (if the queue is not full) and loads the result. Each entry is retired at
// most once.
// Reset (synchronous, active low) empties the queue, clears the peak and sets
// the limit to 65535. A stalled result holds the last step; the next input
// transfer is taken while a finished result still waits on the output.
// ----------------------------------------------------------------------------
module read_depth_clipper
    import rdc_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input items
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [POS_W-1:0] i_read_start,
    input  logic [POS_W-1:0] i_read_end,
    // results
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_keep,
    output logic [OUT_W-1:0] o_occupancy,
    output logic [OUT_W-1:0] o_peak_occupancy,
    output logic             o_overflow,
    // configuration
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [LIM_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int KW = ((CW > LIM_W) ? CW : LIM_W) + 1;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_peak;
    logic [LIM_W-1:0]  r_depth_limit;
    logic [POS_W:0]    r_start_p1;
    logic [POS_W-1:0]  r_end;

    logic [POS_W-1:0]  cell_data [FIFO_DEPTH];
    logic              pop, push, load_out, out_free, fifo_full;
    logic [CW-1:0]     count_after;
    logic [CW-1:0]     peak_after;
    logic              keep_now;
    logic [CW+OUT_W-1:0] occ_ext, peak_ext;

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < FIFO_DEPTH; gi++) begin : g_cell
        t_cell_ctl        cell_ctl;
        logic [POS_W-1:0] next_val;

        assign cell_ctl.shift = pop;
        assign cell_ctl.load  = push && (r_count == CW'(gi));

        if (gi == FIFO_DEPTH - 1) begin : g_last
            assign next_val = cell_data[gi];
        end else begin : g_mid
            assign next_val = cell_data[gi+1];
        end

        rdc_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl),
            .i_next     (next_val),
            .i_load_val (r_end),
            .o_data     (cell_data[gi])
        );
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign out_free    = !o_valid || i_ready;
    assign fifo_full   = (r_count == CW'(FIFO_DEPTH));
    assign count_after = fifo_full ? r_count : r_count + CW'(1);
    assign peak_after  = (count_after > r_peak) ? count_after : r_peak;
    assign keep_now    = (KW'(count_after) + KW'(1)) < KW'(r_depth_limit);

    always_comb begin
        n_state  = r_state;
        pop      = 1'b0;
        push     = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                // Retire one open read a cycle while the new start lies past it.
                if ((r_count != '0) && (r_start_p1 > {1'b0, cell_data[0]})) begin
                    pop = 1'b1;
                end else if (out_free) begin
                    push     = !fifo_full;
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (pop) begin
            n_count = r_count - CW'(1);
        end else if (push) begin
            n_count = r_count + CW'(1);
        end
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_count       <= '0;
            r_peak        <= '0;
            r_depth_limit <= LIMIT_RESET;
            o_valid       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (load_out) begin
                r_peak <= peak_after;
            end
            if (i_cfg_valid) begin
                r_depth_limit <= i_cfg_data;
            end
            if (load_out) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    assign occ_ext  = {{OUT_W{1'b0}}, count_after};
    assign peak_ext = {{OUT_W{1'b0}}, peak_after};

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_start_p1 <= {1'b0, i_read_start} + {{POS_W{1'b0}}, 1'b1};
            r_end      <= i_read_end;
        end
        if (load_out) begin
            o_keep           <= keep_now;
            o_occupancy      <= occ_ext[OUT_W-1:0];
            o_peak_occupancy <= peak_ext[OUT_W-1:0];
            o_overflow       <= fifo_full;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(FIFO_DEPTH))
        else $error("queue occupancy beyond its depth");

    a_peak_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_count)
        else $error("peak occupancy below current occupancy");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_count != '0) && (r_state == ST_RUN))
        else $error("retire from an empty queue");

    a_pop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> r_count == $past(r_count) - CW'(1))
        else $error("retire did not lower occupancy by one");

endmodule
